[rtl/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property that holds in every cycle out of reset
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// a same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// an implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fhss_pkg.sv]
`default_nettype none
package fhss_pkg;

    localparam int CNT_W       = 20;
    localparam int TRK_W       = 8;
    localparam int RCNT_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int RECAL_STEPS = 85;

    // item kinds, also used for the active command
    localparam logic [3:0] MODE_TICK       = 4'd0;
    localparam logic [3:0] MODE_MOTOR_ON   = 4'd1;
    localparam logic [3:0] MODE_MOTOR_OFF  = 4'd2;
    localparam logic [3:0] MODE_RECAL      = 4'd3;
    localparam logic [3:0] MODE_SEEK       = 4'd4;
    localparam logic [3:0] MODE_SIDE       = 4'd5;
    localparam logic [3:0] MODE_PREP_READ  = 4'd6;
    localparam logic [3:0] MODE_PREP_WRITE = 4'd7;
    localparam logic [3:0] MODE_DISK_CHECK = 4'd8;
    localparam logic [3:0] CMD_NONE        = 4'd0;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_NO_TRK00  = 3'd2;
    localparam logic [2:0] ST_BAD_SEC   = 3'd3;
    localparam logic [2:0] ST_PROTECTED = 3'd4;
    localparam logic [2:0] ST_BUSY      = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIR_SETUP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PULSE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_UP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_SETTLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SECTORS     = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SPIN    = 4'd1,
        PH_RCHECK  = 4'd2,
        PH_RSETUP  = 4'd3,
        PH_RPULSE  = 4'd4,
        PH_RRATE   = 4'd5,
        PH_RSETTLE = 4'd6,
        PH_SCHECK  = 4'd7,
        PH_SSETUP  = 4'd8,
        PH_SPULSE  = 4'd9,
        PH_SRATE   = 4'd10,
        PH_SSETTLE = 4'd11,
        PH_SIDE    = 4'd12
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0] dir_setup_ticks;
        logic [CNT_W-1:0] step_pulse_ticks;
        logic [CNT_W-1:0] step_rate_ticks;
        logic [CNT_W-1:0] settle_ticks;
        logic [CNT_W-1:0] spin_up_ticks;
        logic [CNT_W-1:0] side_settle_ticks;
        logic [TRK_W-1:0] track_count;
        logic [7:0]       sectors_per_track;
    } cfg_t;

    typedef struct packed {
        logic [3:0]       mode;
        logic [TRK_W-1:0] target_track;
        logic             side_sel;
        logic [7:0]       sector_num;
        logic             trk00_n;
        logic             wpt_n;
        logic             dskchg_n;
    } item_t;

    typedef struct packed {
        logic             step_line;
        logic             dir_inward;
        logic             motor_line;
        logic             side_line;
        logic             busy_res;
        logic             done_res;
        logic [2:0]       status;
        logic [TRK_W-1:0] track_now;
        logic             disk_seen;
        logic             write_protect;
    } res_t;

endpackage
`default_nettype wire

[rtl/floppy_head_seek_sequencer.sv]
// An accepted item is held in the input register until the result register is
// free or being taken; its result is then offered from the result register.
// Throughput: one item per cycle while results are taken; the sequencer state updates in one pass.
// Reset: synchronous, active low; clears the valid flags of both pipeline stages, the head
// state and lines, and loads the timing and geometry registers with their defaults.
`default_nettype none
`include "assert_macros.svh"
module floppy_head_seek_sequencer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [fhss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fhss_pkg::CNT_W-1:0]     cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // target_track[7:0], side_sel[8], sector_num[16:9], trk00_n[17],
    // wpt_n[18], dskchg_n[19], zero fill[23:20]
    input  wire logic [23:0]                    s_tdata,
    // mode[3:0]
    input  wire logic [3:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // step_line[0], dir_inward[1], motor_line[2], side_line[3], busy_res[4],
    // done_res[5], status[8:6], track_now[16:9], disk_seen[17],
    // write_protect[18], zero fill[23:19]
    output logic [23:0]                         m_tdata
);
    import fhss_pkg::*;

    logic   in_valid_reg;
    item_t  in_item_reg;
    logic   out_valid_reg;
    res_t   out_res_reg;
    res_t   res;
    cfg_t   cfg;
    logic   fire;

    fhss_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fhss_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // an item moves on when the result register is free or being taken
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.mode         <= s_tuser;
            in_item_reg.target_track <= s_tdata[7:0];
            in_item_reg.side_sel     <= s_tdata[8];
            in_item_reg.sector_num   <= s_tdata[16:9];
            in_item_reg.trk00_n      <= s_tdata[17];
            in_item_reg.wpt_n        <= s_tdata[18];
            in_item_reg.dskchg_n     <= s_tdata[19];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_res_reg.write_protect,
                       out_res_reg.disk_seen,
                       out_res_reg.track_now,
                       out_res_reg.status,
                       out_res_reg.done_res,
                       out_res_reg.busy_res,
                       out_res_reg.side_line,
                       out_res_reg.motor_line,
                       out_res_reg.dir_inward,
                       out_res_reg.step_line};

    // a finished command leaves the sequencer idle
    `ASSERT_IMPL(a_done_idle, aclk, aresetn, out_valid_reg && out_res_reg.done_res, !out_res_reg.busy_res, "done item reports busy")
    // a rejected command means a sequence is still running
    `ASSERT_IMPL(a_busy_reject, aclk, aresetn, out_valid_reg && out_res_reg.status == ST_BUSY, out_res_reg.busy_res && !out_res_reg.done_res, "busy rejection while idle or done")
    // the step line only pulses inside a sequence
    `ASSERT_IMPL(a_step_busy, aclk, aresetn, out_valid_reg && out_res_reg.step_line, out_res_reg.busy_res, "step line asserted while idle")
    // an item that moves on is offered as a result next cycle
    `ASSERT_NEXT(a_fire_loads, aclk, aresetn, fire, out_valid_reg, "result register not loaded")

endmodule
`default_nettype wire

[rtl/fhss_cfg.sv]
`default_nettype none
module fhss_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [fhss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fhss_pkg::CNT_W-1:0]     cfg_wdata,
    output fhss_pkg::cfg_t                      cfg
);
    import fhss_pkg::*;

    cfg_t cfg_reg;

    // register file, narrow registers keep the low bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dir_setup_ticks   <= CNT_W'(10);
            cfg_reg.step_pulse_ticks  <= CNT_W'(3);
            cfg_reg.step_rate_ticks   <= CNT_W'(3000);
            cfg_reg.settle_ticks      <= CNT_W'(15000);
            cfg_reg.spin_up_ticks     <= CNT_W'(500000);
            cfg_reg.side_settle_ticks <= CNT_W'(100);
            cfg_reg.track_count       <= TRK_W'(80);
            cfg_reg.sectors_per_track <= 8'd18;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DIR_SETUP:   cfg_reg.dir_setup_ticks   <= cfg_wdata;
                REG_STEP_PULSE:  cfg_reg.step_pulse_ticks  <= cfg_wdata;
                REG_STEP_RATE:   cfg_reg.step_rate_ticks   <= cfg_wdata;
                REG_SETTLE:      cfg_reg.settle_ticks      <= cfg_wdata;
                REG_SPIN_UP:     cfg_reg.spin_up_ticks     <= cfg_wdata;
                REG_SIDE_SETTLE: cfg_reg.side_settle_ticks <= cfg_wdata;
                REG_TRACK_COUNT: cfg_reg.track_count       <= cfg_wdata[TRK_W-1:0];
                REG_SECTORS:     cfg_reg.sectors_per_track <= cfg_wdata[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[rtl/fhss_seq.sv]
`default_nettype none
module fhss_seq (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step_en,
    input  wire fhss_pkg::item_t item,
    input  wire fhss_pkg::cfg_t  cfg,
    output fhss_pkg::res_t      res
);
    import fhss_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [3:0]        cmd_reg, cmd_next;
    logic [CNT_W-1:0]  wait_cnt_reg, wait_cnt_next;
    logic [TRK_W-1:0]  head_reg, head_next;
    logic [TRK_W-1:0]  goal_reg, goal_next;
    logic              goal_side_reg, goal_side_next;
    logic [RCNT_W-1:0] recal_reg, recal_next;
    logic              calib_reg, calib_next;
    logic              motor_reg, motor_next;
    logic              side_reg, side_next;
    logic              present_reg, present_next;
    logic              protect_reg, protect_next;
    logic              step_reg, step_next;
    logic              dir_reg, dir_next;
    logic              done_next;
    logic [2:0]        status_next;

    // next state for one item
    always_comb begin
        logic             wait_done;
        logic [CNT_W-1:0] wait_dec;
        logic             do_prep;
        logic             do_seek;

        wait_done      = (wait_cnt_reg <= CNT_W'(1));
        wait_dec       = wait_done ? '0 : wait_cnt_reg - CNT_W'(1);
        do_prep        = 1'b0;
        do_seek        = 1'b0;
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        wait_cnt_next  = wait_cnt_reg;
        head_next      = head_reg;
        goal_next      = goal_reg;
        goal_side_next = goal_side_reg;
        recal_next     = recal_reg;
        calib_next     = calib_reg;
        motor_next     = motor_reg;
        side_next      = side_reg;
        present_next   = present_reg;
        protect_next   = protect_reg;
        step_next      = step_reg;
        dir_next       = dir_reg;
        done_next      = 1'b0;
        status_next    = ST_OK;

        if (item.mode == MODE_TICK) begin
            // one timed action of the running sequence
            case (phase_reg)
                PH_IDLE: begin
                    phase_next = PH_IDLE;
                end
                PH_SPIN: begin
                    wait_cnt_next = wait_dec;
                    if (wait_done) begin
                        if (cmd_reg == MODE_MOTOR_ON) begin
                            phase_next  = PH_IDLE;
                            cmd_next    = CMD_NONE;
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end else begin
                            do_prep = 1'b1;
                        end
                    end
                end
                PH_RCHECK: begin
                    if (recal_reg >= RCNT_W'(RECAL_STEPS)) begin
                        phase_next  = PH_IDLE;
                        cmd_next    = CMD_NONE;
                        done_next   = 1'b1;
                        status_next = ST_NO_TRK00;
                    end else if (!item.trk00_n) begin
                        head_next     = '0;
                        calib_next    = 1'b1;
                        phase_next    = PH_RSETTLE;
                        wait_cnt_next = cfg.settle_ticks;
                    end else begin
                        recal_next    = recal_reg + RCNT_W'(1);
                        dir_next      = 1'b0;
                        phase_next    = PH_RSETUP;
                        wait_cnt_next = cfg.dir_setup_ticks;
                    end
                end
                PH_RSETUP, PH_SSETUP: begin
                    wait_cnt_next = wait_dec;
                    if (wait_done) begin
                        step_next     = 1'b1;
                        phase_next    = (phase_reg == PH_RSETUP) ? PH_RPULSE : PH_SPULSE;
                        wait_cnt_next = cfg.step_pulse_ticks;
                    end
                end
                PH_RPULSE, PH_SPULSE: begin
                    wait_cnt_next = wait_dec;
                    if (wait_done) begin
                        step_next     = 1'b0;
                        phase_next    = (phase_reg == PH_RPULSE) ? PH_RRATE : PH_SRATE;
                        wait_cnt_next = cfg.step_rate_ticks;
                    end
                end
                PH_RRATE: begin
                    wait_cnt_next = wait_dec;
                    if (wait_done) begin
                        phase_next = PH_RCHECK;
                    end
                end
                PH_SRATE: begin
                    wait_cnt_next = wait_dec;
                    if (wait_done) begin
                        head_next  = dir_reg ? head_reg + TRK_W'(1) : head_reg - TRK_W'(1);
                        phase_next = PH_SCHECK;
                    end
                end
                PH_RSETTLE: begin
                    wait_cnt_next = wait_dec;
                    if (wait_done) begin
                        if (cmd_reg == MODE_RECAL) begin
                            phase_next  = PH_IDLE;
                            cmd_next    = CMD_NONE;
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end else begin
                            phase_next = PH_SCHECK;
                        end
                    end
                end
                PH_SCHECK: begin
                    if (head_reg == goal_reg) begin
                        phase_next    = PH_SSETTLE;
                        wait_cnt_next = cfg.settle_ticks;
                    end else begin
                        dir_next      = (goal_reg > head_reg);
                        phase_next    = PH_SSETUP;
                        wait_cnt_next = cfg.dir_setup_ticks;
                    end
                end
                PH_SSETTLE: begin
                    wait_cnt_next = wait_dec;
                    if (wait_done) begin
                        if (cmd_reg == MODE_SEEK) begin
                            phase_next  = PH_IDLE;
                            cmd_next    = CMD_NONE;
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end else begin
                            side_next     = goal_side_reg;
                            phase_next    = PH_SIDE;
                            wait_cnt_next = cfg.side_settle_ticks;
                        end
                    end
                end
                PH_SIDE: begin
                    wait_cnt_next = wait_dec;
                    if (wait_done) begin
                        phase_next  = PH_IDLE;
                        cmd_next    = CMD_NONE;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    cmd_next   = CMD_NONE;
                end
            endcase
        end else if (item.mode inside {[MODE_MOTOR_ON:MODE_DISK_CHECK]}) begin
            if (phase_reg != PH_IDLE) begin
                // busy: leave everything alone
                status_next = ST_BUSY;
            end else begin
                cmd_next = item.mode;
                case (item.mode)
                    MODE_MOTOR_ON: begin
                        if (motor_reg) begin
                            phase_next  = PH_IDLE;
                            cmd_next    = CMD_NONE;
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end else begin
                            motor_next    = 1'b1;
                            phase_next    = PH_SPIN;
                            wait_cnt_next = cfg.spin_up_ticks;
                        end
                    end
                    MODE_MOTOR_OFF: begin
                        motor_next  = 1'b0;
                        phase_next  = PH_IDLE;
                        cmd_next    = CMD_NONE;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                    end
                    MODE_RECAL: begin
                        recal_next = '0;
                        phase_next = PH_RCHECK;
                    end
                    MODE_SEEK: begin
                        goal_next = item.target_track;
                        do_seek   = 1'b1;
                    end
                    MODE_SIDE: begin
                        side_next     = item.side_sel;
                        phase_next    = PH_SIDE;
                        wait_cnt_next = cfg.side_settle_ticks;
                    end
                    MODE_PREP_READ, MODE_PREP_WRITE: begin
                        goal_next      = item.target_track;
                        goal_side_next = item.side_sel;
                        if (item.sector_num == 8'd0
                                || item.sector_num > cfg.sectors_per_track) begin
                            phase_next  = PH_IDLE;
                            cmd_next    = CMD_NONE;
                            done_next   = 1'b1;
                            status_next = ST_BAD_SEC;
                        end else if (!motor_reg) begin
                            motor_next    = 1'b1;
                            phase_next    = PH_SPIN;
                            wait_cnt_next = cfg.spin_up_ticks;
                        end else begin
                            do_prep = 1'b1;
                        end
                    end
                    default: begin
                        // disk check
                        present_next = item.dskchg_n;
                        protect_next = !item.wpt_n;
                        phase_next   = PH_IDLE;
                        cmd_next     = CMD_NONE;
                        done_next    = 1'b1;
                        status_next  = ST_OK;
                    end
                endcase
            end
        end

        // preparation: latch write protect, refuse a protected write
        if (do_prep) begin
            protect_next = !item.wpt_n;
            if (cmd_next == MODE_PREP_WRITE && protect_next) begin
                phase_next  = PH_IDLE;
                cmd_next    = CMD_NONE;
                done_next   = 1'b1;
                status_next = ST_PROTECTED;
            end else begin
                do_seek = 1'b1;
            end
        end

        // seek start: range check, recalibrate first when needed
        if (do_seek) begin
            if (goal_next >= cfg.track_count) begin
                phase_next  = PH_IDLE;
                cmd_next    = CMD_NONE;
                done_next   = 1'b1;
                status_next = ST_RANGE;
            end else if (!calib_reg) begin
                recal_next = '0;
                phase_next = PH_RCHECK;
            end else begin
                phase_next = PH_SCHECK;
            end
        end
    end

    // result fields from the updated state
    always_comb begin
        res.step_line     = step_next;
        res.dir_inward    = dir_next;
        res.motor_line    = motor_next;
        res.side_line     = side_next;
        res.busy_res      = (phase_next != PH_IDLE);
        res.done_res      = done_next;
        res.status        = status_next;
        res.track_now     = head_next;
        res.disk_seen     = present_next;
        res.write_protect = protect_next;
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            cmd_reg       <= CMD_NONE;
            wait_cnt_reg  <= '0;
            head_reg      <= '0;
            goal_reg      <= '0;
            goal_side_reg <= 1'b0;
            recal_reg     <= '0;
            calib_reg     <= 1'b0;
            motor_reg     <= 1'b0;
            side_reg      <= 1'b0;
            present_reg   <= 1'b0;
            protect_reg   <= 1'b0;
            step_reg      <= 1'b0;
            dir_reg       <= 1'b0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            wait_cnt_reg  <= wait_cnt_next;
            head_reg      <= head_next;
            goal_reg      <= goal_next;
            goal_side_reg <= goal_side_next;
            recal_reg     <= recal_next;
            calib_reg     <= calib_next;
            motor_reg     <= motor_next;
            side_reg      <= side_next;
            present_reg   <= present_next;
            protect_reg   <= protect_next;
            step_reg      <= step_next;
            dir_reg       <= dir_next;
        end
    end

endmodule
`default_nettype wire

[tb/sv/floppy_head_seek_sequencer_checker.sv]
`timescale 1ns / 100ps
module floppy_head_seek_sequencer_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [19:0]          cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // target_track[7:0], side_sel[8], sector_num[16:9], trk00_n[17],
    // wpt_n[18], dskchg_n[19], zero fill[23:20]
    input  logic [23:0]          s_tdata,
    // mode[3:0]
    input  logic [3:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // step_line[0], dir_inward[1], motor_line[2], side_line[3], busy_res[4],
    // done_res[5], status[8:6], track_now[16:9], disk_seen[17],
    // write_protect[18], zero fill[23:19]
    input  logic [23:0]          m_tdata,
    output int                   mismatches,
    output int                   pending
);
    import fhss_pkg::*;

    localparam int PRINT_LIMIT = 100;

    // shadow copy of the timing and geometry registers
    cfg_t seq_cfg;

    // sequencer state as the predictor sees it
    logic [TRK_W-1:0]  head_trk;
    logic [TRK_W-1:0]  goal_trk;
    logic              calib;
    logic              motor_q;
    logic              side_q;
    logic              present_q;
    logic              protect_q;
    logic              goal_side_q;
    logic              step_q;
    logic              dir_q;
    logic              done_q;
    logic [2:0]        status_q;
    logic [CNT_W-1:0]  wait_cnt;
    phase_t            ph;
    logic [3:0]        cur_cmd;
    logic [RCNT_W-1:0] recal_cnt;

    // line states expected for the items in flight, oldest first
    res_t expected_lines[$];
    int   res_no;

    task automatic report_field(input string what, input int got, input int want);
        if (got != want) begin
            if (mismatches < PRINT_LIMIT)
                $display("%0t result %0d: %s is %0d, expected %0d",
                         $time, res_no, what, got, want);
            mismatches = mismatches + 1;
        end
    endtask

    function void finish_cmd(input logic [2:0] code);
        ph       = PH_IDLE;
        cur_cmd  = CMD_NONE;
        done_q   = 1'b1;
        status_q = code;
    endfunction

    function void load_wait(input phase_t nxt, input logic [CNT_W-1:0] ticks);
        ph       = nxt;
        wait_cnt = ticks;
    endfunction

    // a wait of n ticks lasts n ticks, a wait of zero lasts one
    function logic wait_expired();
        if (wait_cnt > 1) begin
            wait_cnt = wait_cnt - 1'b1;
            return 1'b0;
        end
        wait_cnt = '0;
        return 1'b1;
    endfunction

    // range check, then recalibrate first if the head position is unknown
    function void begin_seek();
        if (goal_trk >= seq_cfg.track_count) begin
            finish_cmd(ST_RANGE);
        end else if (!calib) begin
            recal_cnt = '0;
            ph        = PH_RCHECK;
        end else begin
            ph = PH_SCHECK;
        end
    endfunction

    function void check_protect(input logic wpt_n);
        protect_q = !wpt_n;
        if (cur_cmd == MODE_PREP_WRITE && protect_q)
            finish_cmd(ST_PROTECTED);
        else
            begin_seek();
    endfunction

    // one tick of the running sequence
    function void advance_phase(input item_t it);
        case (ph)
            PH_SPIN: begin
                if (wait_expired()) begin
                    if (cur_cmd == MODE_MOTOR_ON)
                        finish_cmd(ST_OK);
                    else
                        check_protect(it.wpt_n);
                end
            end
            PH_RCHECK: begin
                if (recal_cnt >= RECAL_STEPS) begin
                    finish_cmd(ST_NO_TRK00);
                end else if (!it.trk00_n) begin
                    head_trk = '0;
                    calib    = 1'b1;
                    load_wait(PH_RSETTLE, seq_cfg.settle_ticks);
                end else begin
                    recal_cnt = recal_cnt + 1'b1;
                    dir_q     = 1'b0;
                    load_wait(PH_RSETUP, seq_cfg.dir_setup_ticks);
                end
            end
            PH_RSETUP: begin
                if (wait_expired()) begin
                    step_q = 1'b1;
                    load_wait(PH_RPULSE, seq_cfg.step_pulse_ticks);
                end
            end
            PH_SSETUP: begin
                if (wait_expired()) begin
                    step_q = 1'b1;
                    load_wait(PH_SPULSE, seq_cfg.step_pulse_ticks);
                end
            end
            PH_RPULSE: begin
                if (wait_expired()) begin
                    step_q = 1'b0;
                    load_wait(PH_RRATE, seq_cfg.step_rate_ticks);
                end
            end
            PH_SPULSE: begin
                if (wait_expired()) begin
                    step_q = 1'b0;
                    load_wait(PH_SRATE, seq_cfg.step_rate_ticks);
                end
            end
            PH_RRATE: begin
                if (wait_expired())
                    ph = PH_RCHECK;
            end
            PH_SRATE: begin
                if (wait_expired()) begin
                    head_trk = dir_q ? head_trk + 1'b1 : head_trk - 1'b1;
                    ph       = PH_SCHECK;
                end
            end
            PH_RSETTLE: begin
                if (wait_expired()) begin
                    if (cur_cmd == MODE_RECAL)
                        finish_cmd(ST_OK);
                    else
                        ph = PH_SCHECK;
                end
            end
            PH_SCHECK: begin
                if (head_trk == goal_trk) begin
                    load_wait(PH_SSETTLE, seq_cfg.settle_ticks);
                end else begin
                    dir_q = (goal_trk > head_trk);
                    load_wait(PH_SSETUP, seq_cfg.dir_setup_ticks);
                end
            end
            PH_SSETTLE: begin
                if (wait_expired()) begin
                    if (cur_cmd == MODE_SEEK) begin
                        finish_cmd(ST_OK);
                    end else begin
                        side_q = goal_side_q;
                        load_wait(PH_SIDE, seq_cfg.side_settle_ticks);
                    end
                end
            end
            PH_SIDE: begin
                if (wait_expired())
                    finish_cmd(ST_OK);
            end
            default: begin
                ph      = PH_IDLE;
                cur_cmd = CMD_NONE;
            end
        endcase
    endfunction

    // start of a command while the sequencer is idle
    function void issue_command(input item_t it);
        cur_cmd = it.mode;
        case (it.mode)
            MODE_MOTOR_ON: begin
                if (motor_q) begin
                    finish_cmd(ST_OK);
                end else begin
                    motor_q = 1'b1;
                    load_wait(PH_SPIN, seq_cfg.spin_up_ticks);
                end
            end
            MODE_MOTOR_OFF: begin
                motor_q = 1'b0;
                finish_cmd(ST_OK);
            end
            MODE_RECAL: begin
                recal_cnt = '0;
                ph        = PH_RCHECK;
            end
            MODE_SEEK: begin
                goal_trk = it.target_track;
                begin_seek();
            end
            MODE_SIDE: begin
                side_q = it.side_sel;
                load_wait(PH_SIDE, seq_cfg.side_settle_ticks);
            end
            MODE_PREP_READ, MODE_PREP_WRITE: begin
                goal_trk    = it.target_track;
                goal_side_q = it.side_sel;
                if (it.sector_num == 0 || it.sector_num > seq_cfg.sectors_per_track) begin
                    finish_cmd(ST_BAD_SEC);
                end else if (!motor_q) begin
                    motor_q = 1'b1;
                    load_wait(PH_SPIN, seq_cfg.spin_up_ticks);
                end else begin
                    check_protect(it.wpt_n);
                end
            end
            default: begin
                present_q = it.dskchg_n;
                protect_q = !it.wpt_n;
                finish_cmd(ST_OK);
            end
        endcase
    endfunction

    // line states after one item
    function res_t seq_step(input item_t it);
        res_t r;
        done_q   = 1'b0;
        status_q = ST_OK;
        if (it.mode == MODE_TICK) begin
            if (ph != PH_IDLE)
                advance_phase(it);
        end else if (it.mode <= MODE_DISK_CHECK) begin
            if (ph != PH_IDLE)
                status_q = ST_BUSY;
            else
                issue_command(it);
        end
        r.step_line     = step_q;
        r.dir_inward    = dir_q;
        r.motor_line    = motor_q;
        r.side_line     = side_q;
        r.busy_res      = (ph != PH_IDLE);
        r.done_res      = done_q;
        r.status        = status_q;
        r.track_now     = head_trk;
        r.disk_seen     = present_q;
        r.write_protect = protect_q;
        return r;
    endfunction

    // register writes, result comparison and prediction, all at the rising edge
    always @(posedge aclk) begin
        item_t it;
        res_t  want;
        if (!aresetn) begin
            seq_cfg.dir_setup_ticks   = 20'd10;
            seq_cfg.step_pulse_ticks  = 20'd3;
            seq_cfg.step_rate_ticks   = 20'd3000;
            seq_cfg.settle_ticks      = 20'd15000;
            seq_cfg.spin_up_ticks     = 20'd500000;
            seq_cfg.side_settle_ticks = 20'd100;
            seq_cfg.track_count       = 8'd80;
            seq_cfg.sectors_per_track = 8'd18;
            head_trk    = '0;
            goal_trk    = '0;
            calib       = 1'b0;
            motor_q     = 1'b0;
            side_q      = 1'b0;
            present_q   = 1'b0;
            protect_q   = 1'b0;
            goal_side_q = 1'b0;
            step_q      = 1'b0;
            dir_q       = 1'b0;
            done_q      = 1'b0;
            status_q    = ST_OK;
            wait_cnt    = '0;
            ph          = PH_IDLE;
            cur_cmd     = CMD_NONE;
            recal_cnt   = '0;
            expected_lines.delete();
            res_no      = 0;
            mismatches  = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DIR_SETUP:   seq_cfg.dir_setup_ticks   = cfg_wdata;
                    REG_STEP_PULSE:  seq_cfg.step_pulse_ticks  = cfg_wdata;
                    REG_STEP_RATE:   seq_cfg.step_rate_ticks   = cfg_wdata;
                    REG_SETTLE:      seq_cfg.settle_ticks      = cfg_wdata;
                    REG_SPIN_UP:     seq_cfg.spin_up_ticks     = cfg_wdata;
                    REG_SIDE_SETTLE: seq_cfg.side_settle_ticks = cfg_wdata;
                    REG_TRACK_COUNT: seq_cfg.track_count       = cfg_wdata[7:0];
                    default:         seq_cfg.sectors_per_track = cfg_wdata[7:0];
                endcase
            end
            if (m_tvalid && m_tready) begin
                res_no = res_no + 1;
                if (expected_lines.size() == 0) begin
                    report_field("result with no item behind it", 1, 0);
                end else begin
                    want = expected_lines.pop_front();
                    report_field("step_line", m_tdata[0], want.step_line);
                    report_field("dir_inward", m_tdata[1], want.dir_inward);
                    report_field("motor_line", m_tdata[2], want.motor_line);
                    report_field("side_line", m_tdata[3], want.side_line);
                    report_field("busy_res", m_tdata[4], want.busy_res);
                    report_field("done_res", m_tdata[5], want.done_res);
                    report_field("status", m_tdata[8:6], want.status);
                    report_field("track_now", m_tdata[16:9], want.track_now);
                    report_field("disk_seen", m_tdata[17], want.disk_seen);
                    report_field("write_protect", m_tdata[18], want.write_protect);
                    report_field("zero fill", m_tdata[23:19], 0);
                end
            end
            if (s_tvalid && s_tready) begin
                it.mode         = s_tuser;
                it.target_track = s_tdata[7:0];
                it.side_sel     = s_tdata[8];
                it.sector_num   = s_tdata[16:9];
                it.trk00_n      = s_tdata[17];
                it.wpt_n        = s_tdata[18];
                it.dskchg_n     = s_tdata[19];
                expected_lines.push_back(seq_step(it));
            end
        end
        pending = expected_lines.size();
    end

endmodule

[tb/sv/floppy_head_seek_sequencer_test.sv]
`timescale 1ns / 100ps
module floppy_head_seek_sequencer_test;
    import fhss_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 320;
    localparam int PHASES          = 4;
    localparam int TICK_CAP        = 4000;
    localparam int BUSY_BIT        = 4;
    localparam int DRAIN_CYCLES    = 20;
    localparam logic [19:0] WAIT_MAX = 20'hFFFFF;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [3:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;

    int mismatches;
    int pending;
    int n_sent    = 0;
    int res_count = 0;
    int idle_mark = 0;
    int quiet     = 0;
    logic hold_req  = 1'b0;
    logic tx_burst  = 1'b0;
    logic [7:0] track_lim = 8'd80;
    logic [7:0] sector_lim = 8'd18;

    always #5 aclk = ~aclk;

    floppy_head_seek_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    floppy_head_seek_sequencer_checker i_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // watchdog: too long without any item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // note the latest result that showed the sequencer idle, to pace the ticks
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            res_count = res_count + 1;
            if (!m_tdata[BUSY_BIT])
                idle_mark = res_count;
        end
    end

    // result side: random stalls, bursts without stalls, one long hold-off
    initial begin
        int gap;
        int n;
        logic rx_burst;
        n        = 0;
        rx_burst = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                repeat (HOLD_OFF_CYCLES) @(negedge aclk) m_tready <= 1'b0;
                hold_req = 1'b0;
            end
            if (n % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            n = n + 1;
            gap = rx_burst ? 0 : $urandom_range(0, 5);
            repeat (gap) @(negedge aclk) m_tready <= 1'b0;
            @(negedge aclk) m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    function automatic logic [23:0] pack_item(input logic [7:0] tgt, input logic sd,
                                              input logic [7:0] sec, input logic trk_n,
                                              input logic wp_n, input logic dk_n);
        return {4'b0000, dk_n, wp_n, trk_n, sec, sd, tgt};
    endfunction

    // offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic [3:0] kind, input logic [23:0] payload);
        int gap;
        if (n_sent % 40 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        repeat (gap) @(negedge aclk) s_tvalid <= 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent = n_sent + 1;
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [19:0] dir_setup, input logic [19:0] pulse,
                            input logic [19:0] rate, input logic [19:0] settle,
                            input logic [19:0] spin, input logic [19:0] side_wait,
                            input logic [7:0] tracks, input logic [7:0] sectors);
        drain();
        write_reg(REG_DIR_SETUP, dir_setup);
        write_reg(REG_STEP_PULSE, pulse);
        write_reg(REG_STEP_RATE, rate);
        write_reg(REG_SETTLE, settle);
        write_reg(REG_SPIN_UP, spin);
        write_reg(REG_SIDE_SETTLE, side_wait);
        write_reg(REG_TRACK_COUNT, {12'd0, tracks});
        write_reg(REG_SECTORS, {12'd0, sectors});
        track_lim  = tracks;
        sector_lim = sectors;
    endtask

    // ticks, with a stray command now and then, until a result after the command shows the
    // sequencer idle or TICK_CAP items are sent; track zero shows up one time in zero_odds (never when zero_odds is 0)
    task automatic tick_until_idle(input int cmd_no, input int zero_odds, input logic wp_n);
        int ticks;
        logic trk_n;
        ticks = 0;
        while (idle_mark < cmd_no && ticks < TICK_CAP) begin
            trk_n = (zero_odds == 0) ? 1'b1 : ($urandom_range(1, zero_odds) != 1);
            if ($urandom_range(0, 19) == 0)
                send_item(4'($urandom_range(1, 8)),
                          pack_item(8'($urandom), 1'($urandom), 8'($urandom),
                                    1'($urandom), 1'($urandom), 1'($urandom)));
            else
                send_item(MODE_TICK,
                          pack_item(8'($urandom), 1'($urandom), 8'($urandom),
                                    trk_n, wp_n, 1'($urandom)));
            ticks = ticks + 1;
        end
    endtask

    task automatic run_cmd(input logic [3:0] kind, input logic [7:0] tgt, input logic sd,
                           input logic [7:0] sec, input logic wp_n, input logic dk_n,
                           input int zero_odds);
        send_item(kind, pack_item(tgt, sd, sec, 1'($urandom), wp_n, dk_n));
        tick_until_idle(n_sent, zero_odds, wp_n);
    endtask

    initial begin
        int r;
        int odds;
        int phase_no;
        int phase_start;
        int busy_start;
        logic drained;
        logic [3:0] kind;
        logic [7:0] tgt;
        logic [7:0] sec;
        logic [7:0] near_hi;
        logic [7:0] tracks;
        logic [7:0] sectors;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // short waits for the directed part
        set_regs(20'd0, 20'd1, 20'd0, 20'd0, 20'd3, 20'd1, 8'd20, 8'd18);

        // idle tick, disk check, uncalibrated preparations
        send_item(MODE_TICK, pack_item(8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0));
        run_cmd(MODE_DISK_CHECK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b1, 4);
        run_cmd(MODE_PREP_READ, 8'd7, 1'b1, 8'd0, 1'b1, 1'b1, 3);
        run_cmd(MODE_PREP_READ, 8'd7, 1'b1, 8'd18, 1'b1, 1'b1, 3);

        // seeks: range edges and out of range
        run_cmd(MODE_SEEK, 8'd255, 1'b0, 8'd1, 1'b1, 1'b1, 3);
        run_cmd(MODE_SEEK, 8'd19, 1'b0, 8'd1, 1'b1, 1'b1, 3);
        run_cmd(MODE_SEEK, 8'd0, 1'b0, 8'd1, 1'b1, 1'b1, 3);

        // recalibrate that never sees track zero, then one that does
        run_cmd(MODE_RECAL, 8'd0, 1'b0, 8'd1, 1'b1, 1'b1, 0);
        run_cmd(MODE_RECAL, 8'd0, 1'b0, 8'd1, 1'b1, 1'b1, 2);

        // motor and side handling
        run_cmd(MODE_MOTOR_ON, 8'd0, 1'b0, 8'd1, 1'b1, 1'b1, 3);
        run_cmd(MODE_MOTOR_ON, 8'd0, 1'b0, 8'd1, 1'b1, 1'b1, 3);
        run_cmd(MODE_MOTOR_OFF, 8'd0, 1'b0, 8'd1, 1'b1, 1'b1, 3);
        run_cmd(MODE_SIDE, 8'd0, 1'b1, 8'd1, 1'b1, 1'b1, 3);
        run_cmd(MODE_SIDE, 8'd0, 1'b0, 8'd1, 1'b1, 1'b1, 3);

        // writes: bad sector, protected after spin-up, clean, protected at once; a read out of range
        run_cmd(MODE_PREP_WRITE, 8'd3, 1'b0, 8'd255, 1'b1, 1'b1, 3);
        run_cmd(MODE_PREP_WRITE, 8'd3, 1'b1, 8'd1, 1'b0, 1'b1, 3);
        run_cmd(MODE_MOTOR_OFF, 8'd0, 1'b0, 8'd1, 1'b1, 1'b1, 3);
        run_cmd(MODE_PREP_WRITE, 8'd12, 1'b1, 8'd9, 1'b1, 1'b1, 3);
        run_cmd(MODE_PREP_WRITE, 8'd4, 1'b0, 8'd2, 1'b0, 1'b1, 3);
        run_cmd(MODE_PREP_READ, 8'd200, 1'b0, 8'd5, 1'b1, 1'b1, 3);

        // every command while a seek runs is turned away
        send_item(MODE_SEEK, pack_item(8'd15, 1'b0, 8'd1, 1'b1, 1'b1, 1'b1));
        busy_start = n_sent;
        for (int m = 1; m <= 8; m++)
            send_item(4'(m), pack_item(8'd2, 1'b1, 8'd3, 1'b0, 1'b0, 1'b0));
        tick_until_idle(busy_start, 3, 1'b1);

        // unused modes, disk check of an empty drive
        send_item(4'd9, pack_item(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1));
        send_item(4'd15, pack_item(8'hAA, 1'b0, 8'h55, 1'b0, 1'b1, 1'b0));
        run_cmd(MODE_DISK_CHECK, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0, 3);
        run_cmd(MODE_MOTOR_ON, 8'd0, 1'b0, 8'd1, 1'b1, 1'b1, 3);

        // largest waits: only commands that finish at once
        set_regs(WAIT_MAX, WAIT_MAX, WAIT_MAX, WAIT_MAX, WAIT_MAX, WAIT_MAX, 8'd255, 8'd255);
        run_cmd(MODE_MOTOR_ON, 8'd0, 1'b0, 8'd1, 1'b1, 1'b1, 3);
        run_cmd(MODE_DISK_CHECK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b1, 3);
        run_cmd(MODE_SEEK, 8'd255, 1'b0, 8'd1, 1'b1, 1'b1, 3);
        run_cmd(MODE_PREP_READ, 8'd10, 1'b0, 8'd0, 1'b1, 1'b1, 3);
        run_cmd(MODE_PREP_WRITE, 8'd10, 1'b1, 8'd255, 1'b0, 1'b1, 3);
        set_regs(WAIT_MAX, WAIT_MAX, WAIT_MAX, WAIT_MAX, WAIT_MAX, WAIT_MAX, 8'd1, 8'd1);
        run_cmd(MODE_SEEK, 8'd1, 1'b0, 8'd1, 1'b1, 1'b1, 3);
        run_cmd(MODE_PREP_READ, 8'd0, 1'b0, 8'd2, 1'b1, 1'b1, 3);
        run_cmd(MODE_PREP_WRITE, 8'd0, 1'b0, 8'd1, 1'b0, 1'b1, 3);
        run_cmd(MODE_PREP_READ, 8'd1, 1'b1, 8'd1, 1'b1, 1'b1, 3);

        // random phases, each with its own register settings
        for (phase_no = 0; phase_no < PHASES; phase_no++) begin
            case (phase_no)
                0:       begin tracks = 8'($urandom_range(2, 40)); sectors = 8'($urandom_range(1, 30)); end
                1:       begin tracks = 8'd255; sectors = 8'd255; end
                2:       begin tracks = 8'd80;  sectors = 8'd18;  end
                default: begin tracks = 8'($urandom_range(1, 8)); sectors = 8'd1; end
            endcase
            set_regs(20'($urandom_range(0, 3)), 20'($urandom_range(1, 3)),
                     20'($urandom_range(0, 3)), 20'($urandom_range(0, 6)),
                     20'($urandom_range(0, 8)), 20'($urandom_range(0, 4)),
                     tracks, sectors);
            near_hi     = (track_lim > 24) ? 8'd23 : track_lim - 1'b1;
            phase_start = n_sent;
            drained     = 1'b0;
            // the result side holds off while items keep coming
            if (phase_no == 1)
                hold_req = 1'b1;
            while (n_sent - phase_start < RANDOM_ITEMS / PHASES) begin
                if (phase_no == 2 && !drained && n_sent - phase_start > RANDOM_ITEMS / 8) begin
                    drain();
                    drained = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    send_item(4'($urandom),
                              pack_item(8'($urandom), 1'($urandom), 8'($urandom),
                                        1'($urandom), 1'($urandom), 1'($urandom)));
                end else begin
                    kind = 4'($urandom_range(1, 8));
                    tgt  = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, near_hi));
                    sec  = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(1, sector_lim));
                    odds = ($urandom_range(0, 24) == 0) ? 0 : $urandom_range(1, 6);
                    run_cmd(kind, tgt, 1'($urandom), sec, ($urandom_range(0, 3) != 0),
                            1'($urandom), odds);
                end
            end
        end

        // wait out every result, then the pipeline
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
